// ----- rtl/core/b64e_pkg.sv -----
// Shared types, character constants and the symbol table of the base64 stream encoder.
// Has no dependencies; every other file of the encoder imports it.
package b64e_pkg;

    // Input request: one raw byte and the end-of-message flag
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // Output request: one ASCII character
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // Work handed from the front end to the back end: up to four characters
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] chars;
        logic            last;
    } job_t;

    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned COUNT_W = 11;

    // Position of the next byte within its group of three
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    localparam logic [7:0] CHAR_PAD = 8'h3d;
    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_LF  = 8'h0a;

    localparam logic [COUNT_W-1:0] QUARTET_LEN = COUNT_W'(4);

    // Standard alphabet: 6-bit value to ASCII symbol
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            return 8'h41 + v8;
        else if (v < 6'd52)
            return 8'h61 + v8 - 8'd26;
        else if (v < 6'd62)
            return 8'h30 + v8 - 8'd52;
        else if (v == 6'd62)
            return 8'h2b;
        else
            return 8'h2f;
    endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
// Front end: accepts bytes, tracks group phase, carry bits and line count,
// and turns each byte into a job of one to four characters. Uses b64e_pkg.
module b64e_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b64e_pkg::in_item_t    in_data,
    input  logic [9:0]            line_limit,
    output logic                  push,
    output b64e_pkg::job_t        push_job,
    input  logic                  push_ready
);
    import b64e_pkg::*;

    logic [1:0]         phase_reg,  phase_next;
    logic [3:0]         carry_reg,  carry_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         b;
    logic               last;

    assign in_ready = push_ready;
    assign push     = in_valid && push_ready;
    assign b        = in_data.in_byte;
    assign last     = in_data.in_last;
    assign count_inc = count_reg + QUARTET_LEN;

    // Classify the byte by phase and build its characters
    always_comb
    begin
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        count_next     = count_reg;
        push_job.cnt   = 3'd1;
        push_job.chars = '0;
        push_job.last  = last;
        case (phase_reg)
            PH_1:
            begin
                push_job.chars[0] = b64_symbol({carry_reg[1:0], b[7:4]});
                carry_next = b[3:0];
                phase_next = PH_2;
                if (last)
                begin
                    push_job.chars[1] = b64_symbol({b[3:0], 2'b00});
                    push_job.chars[2] = CHAR_PAD;
                    push_job.cnt      = 3'd3;
                end
            end
            PH_2:
            begin
                push_job.chars[0] = b64_symbol({carry_reg, b[7:6]});
                push_job.chars[1] = b64_symbol(b[5:0]);
                push_job.cnt      = 3'd2;
                carry_next = 4'd0;
                phase_next = PH_0;
                count_next = count_inc;
                // Line full: append CR LF
                if ((line_limit != '0) && (count_inc >= {1'b0, line_limit}))
                begin
                    push_job.chars[2] = CHAR_CR;
                    push_job.chars[3] = CHAR_LF;
                    push_job.cnt      = 3'd4;
                    count_next        = '0;
                end
            end
            default:
            begin
                // Phase 0; the unused code behaves the same
                push_job.chars[0] = b64_symbol(b[7:2]);
                carry_next = {2'b00, b[1:0]};
                phase_next = PH_1;
                if (last)
                begin
                    push_job.chars[1] = b64_symbol({b[1:0], 4'b0000});
                    push_job.chars[2] = CHAR_PAD;
                    push_job.chars[3] = CHAR_PAD;
                    push_job.cnt      = 3'd4;
                end
            end
        endcase
        // End of message restarts everything
        if (last)
        begin
            phase_next = PH_0;
            carry_next = 4'd0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            carry_reg <= 4'd0;
            count_reg <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/b64e_queue.sv -----
// Short job queue between front and back end so each side stalls on its own.
// Uses b64e_pkg for the job type.
module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  b64e_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_pop,
    output b64e_pkg::job_t rd_data
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    // Pointer and fill count update with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/core/b64e_back.sv -----
// Back end: holds one job and hands out its characters one per cycle
// while out_ready is high. Uses b64e_pkg for the job and output types.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_pop,
    input  b64e_pkg::job_t      job_data,
    output logic                out_valid,
    input  logic                out_ready,
    output b64e_pkg::out_item_t out_data
);
    import b64e_pkg::*;

    logic       busy_reg, busy_next;
    job_t       job_reg,  job_next;
    logic [1:0] idx_reg,  idx_next;
    logic       final_char;
    logic       fire;
    logic       load;

    assign final_char = ({1'b0, idx_reg} == (job_reg.cnt - 3'd1));
    assign fire       = busy_reg && out_ready;
    assign load       = !busy_reg || (fire && final_char);
    assign job_pop    = load && job_valid;

    assign out_valid         = busy_reg;
    assign out_data.out_char = job_reg.chars[idx_reg];
    assign out_data.out_last = job_reg.last && final_char;

    // Load the next job when empty or on the final character, else step
    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = job_valid;
            job_next  = job_data;
            idx_next  = 2'd0;
        end
        else if (fire)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// ----- rtl/core/base64_stream_encoder_top.sv -----
// Top level of the base64 stream encoder: front end, job queue, back end
// and the line limit register. Depends on b64e_pkg and the three submodules.
//
//   channel | direction | payload         | request moves
//   in      | input     | in_item_t       | one raw byte, in_last flag
//   out     | output    | out_item_t      | one ASCII character
//   cfg     | input     | 10-bit limit    | new line_limit, taken at once
//
// The front end takes a byte whenever the queue has room.
// The back end sends one character per cycle while out_ready is high; a byte
// makes 1 to 4 of them, so the sustained rate is set by the output port. The
// first character of a byte passes the queue, then the job register.
// Reset clears phase, carry, line count, line_limit, queue and back end.
// An output stall fills the queue, then drops in_ready.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64e_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output b64e_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [9:0]          cfg_data
);
    import b64e_pkg::*;

    logic [LIMIT_W-1:0] line_limit_reg;
    logic               push;
    job_t               push_job;
    logic               push_ready;
    logic               job_valid;
    logic               job_pop;
    job_t               job_data;

    assign cfg_ready = 1'b1;

    // Line limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_limit_reg <= '0;
        else if (cfg_valid && cfg_ready)
            line_limit_reg <= cfg_data;
    end

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .line_limit (line_limit_reg),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_data  (push_job),
        .rd_valid (job_valid),
        .rd_pop   (job_pop),
        .rd_data  (job_data)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job_data  (job_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/core/b64e_checker.sv -----
// Port-level checks of the base64 stream encoder output, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder_top.
module b64e_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input b64e_pkg::out_item_t out_data
);
    import b64e_pkg::*;

    logic [7:0] c;
    assign c = out_data.out_char;

    // Stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request changed while stalled");

    // Only alphabet symbols, pad, CR or LF leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
                       (c >= 8'h30 && c <= 8'h39) || c == 8'h2b || c == 8'h2f ||
                       c == CHAR_PAD || c == CHAR_CR || c == CHAR_LF))
        else $error("character outside the output set");

    // A pad that does not end the message is followed by another pad
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && c == CHAR_PAD && !out_data.out_last |=> out_valid && c == CHAR_PAD)
        else $error("padding broken off");

    // CR is followed by LF, or repeats while stalled; CR never ends a message
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && c == CHAR_CR |=> out_valid && (c == CHAR_LF || c == CHAR_CR))
        else $error("CR not followed by LF");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
